// ===== design/pit3d_pkg.sv =====
// ----------------------------------------------------------------------------
// pit3d_pkg
// Shared constants and control types for the 3-D point-in-triangle pipeline.
// ----------------------------------------------------------------------------
package pit3d_pkg;

    // Default coordinate width
    localparam int C_COORD_WIDTH = 16;

    // Vector axes
    localparam int C_AXES = 3;
    localparam int C_X    = 0;
    localparam int C_Y    = 1;
    localparam int C_Z    = 2;

    // Beat layout
    localparam int C_IN_FIELDS    = 12;
    localparam int C_OUT_FIELDS   = 3;
    localparam int C_OUT_TDATA_W  = 8;

    // Pipeline stage numbers, 1 = first register after the input
    localparam int C_STG_DIFF  = 1;
    localparam int C_STG_MUL   = 2;
    localparam int C_STG_CROSS = 3;
    localparam int C_STG_PART  = 4;
    localparam int C_STG_PROD  = 5;
    localparam int C_STG_SUM   = 6;
    localparam int C_STG_OUT   = 7;
    localparam int C_NUM_STAGES = 7;

    // Load enables for the cross-product unit
    typedef struct packed {
        logic mul;
        logic sub;
    } t_cross_en;

    // Load enables for the dot-product unit
    typedef struct packed {
        logic part;
        logic prod;
        logic sum;
    } t_dot_en;

    // Test applied to a finished dot sum
    typedef enum logic {
        DOT_NONNEG = 1'b0,
        DOT_ZERO   = 1'b1
    } t_dot_test;

endpackage

// ===== design/pit3d_diff.sv =====
// ----------------------------------------------------------------------------
// pit3d_diff
// First stage: edge and offset vectors between the point and the vertices.
// ----------------------------------------------------------------------------
module pit3d_diff
    import pit3d_pkg::*;
#(
    parameter int W = C_COORD_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_pt   [C_AXES],
    input  logic signed [W-1:0] i_v1   [C_AXES],
    input  logic signed [W-1:0] i_v2   [C_AXES],
    input  logic signed [W-1:0] i_v3   [C_AXES],
    output logic signed [W:0]   o_v3v2 [C_AXES],
    output logic signed [W:0]   o_ptv2 [C_AXES],
    output logic signed [W:0]   o_v1v2 [C_AXES],
    output logic signed [W:0]   o_v3v1 [C_AXES],
    output logic signed [W:0]   o_ptv1 [C_AXES],
    output logic signed [W:0]   o_v2v1 [C_AXES]
);

    logic signed [W:0] n_v3v2 [C_AXES];
    logic signed [W:0] n_ptv2 [C_AXES];
    logic signed [W:0] n_v1v2 [C_AXES];
    logic signed [W:0] n_v3v1 [C_AXES];
    logic signed [W:0] n_ptv1 [C_AXES];
    logic signed [W:0] n_v2v1 [C_AXES];

    // Sign-extend by one bit so no difference can wrap
    always_comb begin
        for (int i = 0; i < C_AXES; i++) begin
            n_v3v2[i] = {i_v3[i][W-1], i_v3[i]} - {i_v2[i][W-1], i_v2[i]};
            n_ptv2[i] = {i_pt[i][W-1], i_pt[i]} - {i_v2[i][W-1], i_v2[i]};
            n_v1v2[i] = {i_v1[i][W-1], i_v1[i]} - {i_v2[i][W-1], i_v2[i]};
            n_v3v1[i] = {i_v3[i][W-1], i_v3[i]} - {i_v1[i][W-1], i_v1[i]};
            n_ptv1[i] = {i_pt[i][W-1], i_pt[i]} - {i_v1[i][W-1], i_v1[i]};
            n_v2v1[i] = {i_v2[i][W-1], i_v2[i]} - {i_v1[i][W-1], i_v1[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < C_AXES; i++) begin
                o_v3v2[i] <= n_v3v2[i];
                o_ptv2[i] <= n_ptv2[i];
                o_v1v2[i] <= n_v1v2[i];
                o_v3v1[i] <= n_v3v1[i];
                o_ptv1[i] <= n_ptv1[i];
                o_v2v1[i] <= n_v2v1[i];
            end
        end
    end

endmodule

// ===== design/pit3d_cross.sv =====
// ----------------------------------------------------------------------------
// pit3d_cross
// Two-stage cross product: six registered products, then the differences.
// ----------------------------------------------------------------------------
module pit3d_cross
    import pit3d_pkg::*;
#(
    parameter int WI = C_COORD_WIDTH + 1
) (
    input  logic                   i_clk,
    input  t_cross_en              i_en,
    input  logic signed [WI-1:0]   i_a [C_AXES],
    input  logic signed [WI-1:0]   i_b [C_AXES],
    output logic signed [2*WI:0]   o_c [C_AXES]
);

    localparam int WP    = 2 * WI;
    localparam int NPROD = 2 * C_AXES;

    logic signed [WP-1:0] n_p [NPROD];
    logic signed [WP-1:0] r_p [NPROD];
    logic signed [WP:0]   n_c [C_AXES];

    // Products in pairs: (ay*bz, az*by), (az*bx, ax*bz), (ax*by, ay*bx)
    always_comb begin
        n_p[0] = i_a[C_Y] * i_b[C_Z];
        n_p[1] = i_a[C_Z] * i_b[C_Y];
        n_p[2] = i_a[C_Z] * i_b[C_X];
        n_p[3] = i_a[C_X] * i_b[C_Z];
        n_p[4] = i_a[C_X] * i_b[C_Y];
        n_p[5] = i_a[C_Y] * i_b[C_X];
    end

    always_comb begin
        for (int i = 0; i < C_AXES; i++) begin
            n_c[i] = {r_p[2*i][WP-1], r_p[2*i]} - {r_p[2*i+1][WP-1], r_p[2*i+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            for (int i = 0; i < NPROD; i++) begin
                r_p[i] <= n_p[i];
            end
        end
        if (i_en.sub) begin
            for (int i = 0; i < C_AXES; i++) begin
                o_c[i] <= n_c[i];
            end
        end
    end

endmodule

// ===== design/pit3d_dot.sv =====
// ----------------------------------------------------------------------------
// pit3d_dot
// Three-stage exact dot product whose last stage registers a sign or zero test. Each
// operand is split in halves so every multiplier stays near the operand half width.
// ----------------------------------------------------------------------------
module pit3d_dot
    import pit3d_pkg::*;
#(
    parameter int        WA   = C_COORD_WIDTH + 1,
    parameter int        WB   = 2 * C_COORD_WIDTH + 3,
    parameter t_dot_test TEST = DOT_NONNEG
) (
    input  logic                 i_clk,
    input  t_dot_en              i_en,
    input  logic signed [WA-1:0] i_a [C_AXES],
    input  logic signed [WB-1:0] i_b [C_AXES],
    output logic                 o_pass
);

    localparam int KA  = WA / 2;
    localparam int HA  = WA - KA;
    localparam int KB  = WB / 2;
    localparam int HB  = WB - KB;
    localparam int WHH = HA + HB;
    localparam int WHL = HA + KB + 1;
    localparam int WLH = KA + HB + 1;
    localparam int WLL = KA + KB;
    localparam int WP  = WA + WB;
    localparam int WS  = WP + 2;

    logic signed [WHH-1:0] n_hh [C_AXES];
    logic signed [WHL-1:0] n_hl [C_AXES];
    logic signed [WLH-1:0] n_lh [C_AXES];
    logic        [WLL-1:0] n_ll [C_AXES];
    logic signed [WHH-1:0] r_hh [C_AXES];
    logic signed [WHL-1:0] r_hl [C_AXES];
    logic signed [WLH-1:0] r_lh [C_AXES];
    logic        [WLL-1:0] r_ll [C_AXES];
    logic        [WP-1:0]  n_prod [C_AXES];
    logic        [WP-1:0]  r_prod [C_AXES];
    logic        [WS-1:0]  n_sum;

    // Partial products: high halves signed, low halves unsigned
    always_comb begin
        for (int i = 0; i < C_AXES; i++) begin
            n_hh[i] = $signed(i_a[i][WA-1:KA]) * $signed(i_b[i][WB-1:KB]);
            n_hl[i] = $signed(i_a[i][WA-1:KA]) * $signed({1'b0, i_b[i][KB-1:0]});
            n_lh[i] = $signed({1'b0, i_a[i][KA-1:0]}) * $signed(i_b[i][WB-1:KB]);
            n_ll[i] = i_a[i][KA-1:0] * i_b[i][KB-1:0];
        end
    end

    // Recombine, modulo 2^WP, which holds the exact product; the high half of
    // a weighs 2^KA and the high half of b weighs 2^KB
    always_comb begin
        for (int i = 0; i < C_AXES; i++) begin
            n_prod[i] = ({{(WP-WHH){r_hh[i][WHH-1]}}, r_hh[i]} << (KA + KB))
                      + ({{(WP-WHL){r_hl[i][WHL-1]}}, r_hl[i]} << KA)
                      + ({{(WP-WLH){r_lh[i][WLH-1]}}, r_lh[i]} << KB)
                      + {{(WP-WLL){1'b0}}, r_ll[i]};
        end
    end

    always_comb begin
        n_sum = {{2{r_prod[0][WP-1]}}, r_prod[0]}
              + {{2{r_prod[1][WP-1]}}, r_prod[1]}
              + {{2{r_prod[2][WP-1]}}, r_prod[2]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.part) begin
            for (int i = 0; i < C_AXES; i++) begin
                r_hh[i] <= n_hh[i];
                r_hl[i] <= n_hl[i];
                r_lh[i] <= n_lh[i];
                r_ll[i] <= n_ll[i];
            end
        end
        if (i_en.prod) begin
            for (int i = 0; i < C_AXES; i++) begin
                r_prod[i] <= n_prod[i];
            end
        end
        if (i_en.sum) begin
            if (TEST == DOT_ZERO) begin
                o_pass <= (n_sum == '0);
            end else begin
                o_pass <= !n_sum[WS-1];
            end
        end
    end

endmodule

// ===== design/point_in_triangle_3d.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_3d
// Exact integer same-side point-in-triangle test in 3-D, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Beat contents (lowest bits first)
//  ---------+-----+----------------------------------------------------------
//  s        | in  | point_x/y/z, vert1_x/y/z, vert2_x/y/z, vert3_x/y/z,
//           |     | COORD_WIDTH bits each, zero-filled to whole bytes
//  m        | out | inside_res, within_prism, on_plane, zero-filled to 8 bits
//
//  Throughput is one beat per cycle while the output is not stalled; each
//  beat passes through the registered stages difference -> products -> cross
//  -> partial products -> dot products -> dot sum -> output register.
//  Every stage carries a valid bit and loads whenever it is empty or the
//  stage after it loads, so a stall holds each full stage in place while
//  bubbles ahead of it still close up; nothing is dropped or repeated.
//  Reset (synchronous, active low) clears only the valid bits.
//
module point_in_triangle_3d
    import pit3d_pkg::*;
#(
    parameter int COORD_WIDTH = C_COORD_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Input: point_x, point_y, point_z, vert1_x .. vert3_z, zero pad
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  logic [((C_IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // Output: inside_res, within_prism, on_plane, zero pad
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output logic [C_OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int W  = COORD_WIDTH;
    localparam int WD = W + 1;          // difference vectors
    localparam int WC = 2 * W + 3;      // cross products

    // ---------------- stage control ----------------
    logic [C_NUM_STAGES:1] r_vld;
    logic [C_NUM_STAGES:1] n_vld;
    logic [C_NUM_STAGES:1] w_en;
    logic [C_NUM_STAGES:0] w_vin;

    // A stage loads when it is empty or its successor loads
    always_comb begin
        w_en[C_NUM_STAGES] = !r_vld[C_NUM_STAGES] || i_m_tready;
        for (int k = C_NUM_STAGES - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign w_vin = {r_vld, i_s_tvalid};

    always_comb begin
        for (int k = 1; k <= C_NUM_STAGES; k++) begin
            n_vld[k] = w_en[k] ? w_vin[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_tready = w_en[C_STG_DIFF];
    assign o_m_tvalid = r_vld[C_STG_OUT];

    t_cross_en w_cross_en;
    t_dot_en   w_dot_en;

    assign w_cross_en.mul = w_en[C_STG_MUL];
    assign w_cross_en.sub = w_en[C_STG_CROSS];
    assign w_dot_en.part  = w_en[C_STG_PART];
    assign w_dot_en.prod  = w_en[C_STG_PROD];
    assign w_dot_en.sum   = w_en[C_STG_SUM];

    // ---------------- unpack the input beat ----------------
    logic signed [W-1:0] w_pt [C_AXES];
    logic signed [W-1:0] w_v1 [C_AXES];
    logic signed [W-1:0] w_v2 [C_AXES];
    logic signed [W-1:0] w_v3 [C_AXES];

    always_comb begin
        for (int i = 0; i < C_AXES; i++) begin
            w_pt[i] = i_s_tdata[(0*C_AXES+i)*W +: W];
            w_v1[i] = i_s_tdata[(1*C_AXES+i)*W +: W];
            w_v2[i] = i_s_tdata[(2*C_AXES+i)*W +: W];
            w_v3[i] = i_s_tdata[(3*C_AXES+i)*W +: W];
        end
    end

    // ---------------- stage 1: differences ----------------
    logic signed [WD-1:0] w_v3v2 [C_AXES];
    logic signed [WD-1:0] w_ptv2 [C_AXES];
    logic signed [WD-1:0] w_v1v2 [C_AXES];
    logic signed [WD-1:0] w_v3v1 [C_AXES];
    logic signed [WD-1:0] w_ptv1 [C_AXES];
    logic signed [WD-1:0] w_v2v1 [C_AXES];

    pit3d_diff #(
        .W (W)
    ) u_diff (
        .i_clk  (i_clk),
        .i_en   (w_en[C_STG_DIFF]),
        .i_pt   (w_pt),
        .i_v1   (w_v1),
        .i_v2   (w_v2),
        .i_v3   (w_v3),
        .o_v3v2 (w_v3v2),
        .o_ptv2 (w_ptv2),
        .o_v1v2 (w_v1v2),
        .o_v3v1 (w_v3v1),
        .o_ptv1 (w_ptv1),
        .o_v2v1 (w_v2v1)
    );

    // ---------------- stages 2-3: cross products ----------------
    // Edge (V2,V3) against V1, edge (V1,V3) against V2, edge (V1,V2)
    // against V3; the normal is (V2-V1) x (V3-V1).
    logic signed [WC-1:0] w_x1p [C_AXES];
    logic signed [WC-1:0] w_x1c [C_AXES];
    logic signed [WC-1:0] w_x2p [C_AXES];
    logic signed [WC-1:0] w_x2c [C_AXES];
    logic signed [WC-1:0] w_x3p [C_AXES];
    logic signed [WC-1:0] w_x3c [C_AXES];
    logic signed [WC-1:0] w_nrm [C_AXES];

    pit3d_cross #(.WI(WD)) u_x1p (
        .i_clk(i_clk), .i_en(w_cross_en), .i_a(w_v3v2), .i_b(w_ptv2), .o_c(w_x1p)
    );
    pit3d_cross #(.WI(WD)) u_x1c (
        .i_clk(i_clk), .i_en(w_cross_en), .i_a(w_v3v2), .i_b(w_v1v2), .o_c(w_x1c)
    );
    pit3d_cross #(.WI(WD)) u_x2p (
        .i_clk(i_clk), .i_en(w_cross_en), .i_a(w_v3v1), .i_b(w_ptv1), .o_c(w_x2p)
    );
    pit3d_cross #(.WI(WD)) u_x2c (
        .i_clk(i_clk), .i_en(w_cross_en), .i_a(w_v3v1), .i_b(w_v2v1), .o_c(w_x2c)
    );
    pit3d_cross #(.WI(WD)) u_x3p (
        .i_clk(i_clk), .i_en(w_cross_en), .i_a(w_v2v1), .i_b(w_ptv1), .o_c(w_x3p)
    );
    pit3d_cross #(.WI(WD)) u_x3c (
        .i_clk(i_clk), .i_en(w_cross_en), .i_a(w_v2v1), .i_b(w_v3v1), .o_c(w_x3c)
    );
    pit3d_cross #(.WI(WD)) u_nrm (
        .i_clk(i_clk), .i_en(w_cross_en), .i_a(w_v2v1), .i_b(w_v3v1), .o_c(w_nrm)
    );

    // Hold P-V1 alongside the cross products for the plane test
    logic signed [WD-1:0] r_ptv1_mul [C_AXES];
    logic signed [WD-1:0] r_ptv1_crs [C_AXES];

    always_ff @(posedge i_clk) begin
        if (w_en[C_STG_MUL]) begin
            for (int i = 0; i < C_AXES; i++) begin
                r_ptv1_mul[i] <= w_ptv1[i];
            end
        end
        if (w_en[C_STG_CROSS]) begin
            for (int i = 0; i < C_AXES; i++) begin
                r_ptv1_crs[i] <= r_ptv1_mul[i];
            end
        end
    end

    // ---------------- stages 4-6: dot products ----------------
    // A same-side sum passes when it is not negative (zero counts as the
    // same side); the plane sum passes only when it is exactly zero.
    logic w_pass1, w_pass2, w_pass3, w_plane_zero;

    pit3d_dot #(.WA(WC), .WB(WC), .TEST(DOT_NONNEG)) u_dot1 (
        .i_clk(i_clk), .i_en(w_dot_en), .i_a(w_x1p), .i_b(w_x1c), .o_pass(w_pass1)
    );
    pit3d_dot #(.WA(WC), .WB(WC), .TEST(DOT_NONNEG)) u_dot2 (
        .i_clk(i_clk), .i_en(w_dot_en), .i_a(w_x2p), .i_b(w_x2c), .o_pass(w_pass2)
    );
    pit3d_dot #(.WA(WC), .WB(WC), .TEST(DOT_NONNEG)) u_dot3 (
        .i_clk(i_clk), .i_en(w_dot_en), .i_a(w_x3p), .i_b(w_x3c), .o_pass(w_pass3)
    );
    pit3d_dot #(.WA(WD), .WB(WC), .TEST(DOT_ZERO)) u_plane (
        .i_clk(i_clk), .i_en(w_dot_en), .i_a(r_ptv1_crs), .i_b(w_nrm),
        .o_pass(w_plane_zero)
    );

    // Degenerate triangle: zero normal; carry the flag down to the dot sum
    logic n_degen;
    logic r_degen_part, r_degen_prod, r_degen_sum;

    assign n_degen = (w_nrm[C_X] == '0) && (w_nrm[C_Y] == '0) && (w_nrm[C_Z] == '0);

    always_ff @(posedge i_clk) begin
        if (w_en[C_STG_PART]) begin
            r_degen_part <= n_degen;
        end
        if (w_en[C_STG_PROD]) begin
            r_degen_prod <= r_degen_part;
        end
        if (w_en[C_STG_SUM]) begin
            r_degen_sum <= r_degen_prod;
        end
    end

    // ---------------- stage 7: output register ----------------
    logic n_prism, n_plane;
    logic r_inside, r_prism, r_plane;

    assign n_prism = w_pass1 && w_pass2 && w_pass3;
    assign n_plane = !r_degen_sum && w_plane_zero;

    always_ff @(posedge i_clk) begin
        if (w_en[C_STG_OUT]) begin
            r_prism  <= n_prism;
            r_plane  <= n_plane;
            r_inside <= n_prism && n_plane;
        end
    end

    assign o_m_tdata = {{(C_OUT_TDATA_W-C_OUT_FIELDS){1'b0}}, r_plane, r_prism, r_inside};

endmodule

// ===== tb/sv/tb_point_in_triangle_3d.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_in_triangle_3d
// Stream-level check of the 3-D point-in-triangle pipeline: every query beat
// is classified by an exact 128-bit integer predictor and the flags beat the
// block returns is compared field by field, in order, under random idling,
// a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_point_in_triangle_3d;
    import pit3d_pkg::*;

    localparam int CW           = C_COORD_WIDTH;
    localparam int S_TDATA_W    = ((C_IN_FIELDS*CW+7)/8)*8;
    localparam int RES_INSIDE   = 0;
    localparam int RES_PRISM    = 1;
    localparam int RES_PLANE    = 2;
    localparam int IDLE_PCT     = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4*C_NUM_STAGES;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 20;
    localparam int CMAX         = 32767;
    localparam int CMIN         = -32768;

    // Query fields in beat order: point, vert1, vert2, vert3, x/y/z each
    typedef logic [C_IN_FIELDS-1:0][CW-1:0] t_query;
    typedef logic [C_OUT_FIELDS-1:0] t_flags;
    typedef logic signed [127:0] t_wide;
    typedef struct {
        t_wide x;
        t_wide y;
        t_wide z;
    } t_wvec;

    // Hand-picked corner cases: px py pz, v1 xyz, v2 xyz, v3 xyz
    localparam int DIRECTED_SET [19][12] = '{
        '{1, 1, 0,  0, 0, 0,  4, 0, 0,  0, 4, 0},            // strictly inside
        '{0, 0, 0,  0, 0, 0,  4, 0, 0,  0, 4, 0},            // on a vertex
        '{2, 0, 0,  0, 0, 0,  4, 0, 0,  0, 4, 0},            // on an edge
        '{2, 2, 0,  0, 0, 0,  4, 0, 0,  0, 4, 0},            // on the long edge
        '{5, 5, 0,  0, 0, 0,  4, 0, 0,  0, 4, 0},            // in plane, outside
        '{1, 1, 7,  0, 0, 0,  4, 0, 0,  0, 4, 0},            // in prism, off plane
        '{8, 0, 0,  0, 0, 0,  4, 0, 0,  0, 4, 0},            // on edge line, beyond
        '{1, 1, 0,  0, 0, 0,  0, 4, 0,  4, 0, 0},            // reversed winding
        '{1, 1, 1,  0, 0, 0,  1, 1, 1,  2, 2, 2},            // collinear vertices
        '{3, 3, 3,  3, 3, 3,  3, 3, 3,  3, 3, 3},            // all points equal
        '{1, 0, 0,  0, 0, 0,  4, 0, 0,  4, 0, 0},            // two vertices equal
        '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN},
        '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX},
        '{0, 0, 0,  CMIN, CMIN, 0,  CMAX, CMIN, 0,  CMIN, CMAX, 0},
        '{0, 0, CMAX,  CMIN, CMIN, 0,  CMAX, CMIN, 0,  CMIN, CMAX, 0},
        '{CMIN, CMIN, CMIN,  CMIN, CMIN, CMIN,  CMAX, CMIN, CMAX,  CMIN, CMAX, CMAX},
        '{CMAX, CMAX, CMAX,  CMIN, CMIN, CMIN,  CMAX, CMIN, CMAX,  CMIN, CMAX, CMAX},
        '{CMAX, CMIN, CMAX,  CMIN, CMAX, CMIN,  CMAX, CMAX, CMIN,  -1, 0, 1},
        '{2, 0, 2,  0, 0, 0,  4, 0, 0,  0, 0, 4}             // vertical xz triangle
    };

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // point_x, point_y, point_z, vert1_x .. vert3_z, 16 bits each
    logic [S_TDATA_W-1:0]   i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // inside_res, within_prism, on_plane, zero pad
    logic [C_OUT_TDATA_W-1:0] o_m_tdata;

    t_flags expected_flags [$];
    string  flag_name [C_OUT_FIELDS] = '{"inside_res", "within_prism", "on_plane"};

    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;
    int rx_hold_req = 0;
    int hold_left   = 0;
    int n_errors    = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_inside    = 0;
    int n_prism     = 0;
    int n_plane     = 0;
    int cycles      = 0;

    point_in_triangle_3d #(
        .COORD_WIDTH(CW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Exact predictor: widen every coordinate to 128 bits so no cross or
    // dot product can wrap.
    // ------------------------------------------------------------------
    function automatic t_wvec coord_vec(t_query q, int base);
        t_wvec v;
        v.x = $signed(q[base]);
        v.y = $signed(q[base+1]);
        v.z = $signed(q[base+2]);
        return v;
    endfunction

    function automatic t_wvec vec_diff(t_wvec a, t_wvec b);
        t_wvec r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic t_wvec vec_cross(t_wvec a, t_wvec b);
        t_wvec r;
        r.x = a.y*b.z - a.z*b.y;
        r.y = a.z*b.x - a.x*b.z;
        r.z = a.x*b.y - a.y*b.x;
        return r;
    endfunction

    function automatic t_wide vec_dot(t_wvec a, t_wvec b);
        return a.x*b.x + a.y*b.y + a.z*b.z;
    endfunction

    // Point and opposite vertex on the same side of edge a-b (zero counts)
    function automatic bit same_side(t_wvec p, t_wvec c, t_wvec a, t_wvec b);
        t_wvec side;
        side = vec_diff(b, a);
        return vec_dot(vec_cross(side, vec_diff(p, a)),
                       vec_cross(side, vec_diff(c, a))) >= 0;
    endfunction

    function automatic t_flags classify_point(t_query q);
        t_wvec  p, v1, v2, v3, nrm;
        bit     prism, plane, flat;
        t_flags f;
        p  = coord_vec(q, 0);
        v1 = coord_vec(q, 3);
        v2 = coord_vec(q, 6);
        v3 = coord_vec(q, 9);
        prism = same_side(p, v1, v2, v3) && same_side(p, v2, v1, v3)
             && same_side(p, v3, v1, v2);
        nrm   = vec_cross(vec_diff(v2, v1), vec_diff(v3, v1));
        flat  = (nrm.x == 0) && (nrm.y == 0) && (nrm.z == 0);
        plane = !flat && (vec_dot(vec_diff(p, v1), nrm) == 0);
        f = '0;
        f[RES_INSIDE] = prism && plane;
        f[RES_PRISM]  = prism;
        f[RES_PLANE]  = plane;
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Query generators
    // ------------------------------------------------------------------
    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Well-formed query: triangle spanned by k*e1 and k*e2 from vert1, point
    // at integer barycentric steps, so it lands exactly in the plane.
    function automatic t_query make_planar();
        t_query q;
        int     span, k, a, b, m, rot, ax, j, pv;
        int     v1 [3];
        int     e1 [3];
        int     e2 [3];
        if ($urandom_range(3) == 0) begin
            span = 1024;
            k    = rand_between(1, 2);
        end else begin
            span = 64;
            k    = rand_between(1, 32);
        end
        for (ax = 0; ax < 3; ax++) begin
            v1[ax] = rand_between(-20000, 20000);
            e1[ax] = rand_between(-span, span);
            e2[ax] = rand_between(-span, span);
        end
        // Fold the triangle onto a line now and then
        if ($urandom_range(15) == 0) begin
            m = rand_between(-2, 2);
            for (ax = 0; ax < 3; ax++)
                e2[ax] = e1[ax] * m;
        end
        if ($urandom_range(3) != 0) begin
            a = rand_between(0, k);
            b = rand_between(0, k - a);
        end else begin
            a = rand_between(-k, 2*k);
            b = rand_between(-k, 2*k);
        end
        rot = $urandom_range(2);
        for (ax = 0; ax < 3; ax++) begin
            pv = v1[ax] + a*e1[ax] + b*e2[ax];
            // Nudge the point off the plane on a few beats
            if ($urandom_range(7) == 0)
                pv += rand_between(-1, 1);
            q[ax] = CW'(pv);
            j = (0 + rot) % 3;
            q[3 + 3*j + ax] = CW'(v1[ax]);
            j = (1 + rot) % 3;
            q[3 + 3*j + ax] = CW'(v1[ax] + k*e1[ax]);
            j = (2 + rot) % 3;
            q[3 + 3*j + ax] = CW'(v1[ax] + k*e2[ax]);
        end
        return q;
    endfunction

    // Free query: full-range random coordinates with extremes mixed in
    function automatic t_query make_noise();
        t_query q;
        int     i;
        for (i = 0; i < C_IN_FIELDS; i++) begin
            case ($urandom_range(7))
                0:       q[i] = CW'(CMIN);
                1:       q[i] = CW'(CMAX);
                2:       q[i] = '0;
                3:       q[i] = '1;
                default: q[i] = CW'($urandom);
            endcase
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one beat, hold it until accepted, then queue its expected flags.
    // tvalid stays high on return so back-to-back beats need no toggle.
    task automatic send_query(input t_query q);
        t_flags f;
        while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= q;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        f = classify_point(q);
        expected_flags = {expected_flags, f};
        n_sent++;
        n_inside += f[RES_INSIDE];
        n_prism  += f[RES_PRISM];
        n_plane  += f[RES_PLANE];
    endtask

    // Drop tvalid and hold until every outstanding beat has come back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (expected_flags.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    // Drive tready: a requested hold-off wins, else steady or random idling
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (rx_steady) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic report_mismatch(input string msg);
        if (n_errors < PRINT_LIMIT)
            $display("%0t ns: mismatch on beat %0d: %s", $time, n_checked, msg);
        n_errors++;
    endtask

    // Compare every accepted output beat against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_flags want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_flags.size() == 0) begin
                report_mismatch($sformatf("unexpected beat 0x%h", o_m_tdata));
            end else begin
                want = expected_flags.pop_front();
                for (int f = 0; f < C_OUT_FIELDS; f++) begin
                    if (o_m_tdata[f] !== want[f])
                        report_mismatch($sformatf("%s got %b want %b",
                                        flag_name[f], o_m_tdata[f], want[f]));
                end
                if (o_m_tdata[C_OUT_TDATA_W-1:C_OUT_FIELDS] !== '0)
                    report_mismatch($sformatf("pad bits 0x%h not zero", o_m_tdata));
                n_checked++;
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycles, expected_flags.size());
            $display("[point_in_triangle_3d] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Edges, vertices, degenerate triangles and coordinate extremes
    task automatic test_directed();
        t_query q;
        for (int n = 0; n < 19; n++) begin
            for (int i = 0; i < C_IN_FIELDS; i++)
                q[i] = CW'(DIRECTED_SET[n][i]);
            send_query(q);
        end
    endtask

    task automatic test_planar(input int count);
        repeat (count)
            send_query(make_planar());
    endtask

    task automatic test_noise(input int count);
        repeat (count)
            send_query(make_noise());
    endtask

    // Hold the output off for a long stretch while beats keep coming, so the
    // pipeline fills and stalls its input
    task automatic test_backpressure(input int count);
        tx_steady   = 1'b1;
        rx_hold_req = HOLD_CYCLES;
        repeat (count) begin
            if ($urandom_range(1) == 0)
                send_query(make_planar());
            else
                send_query(make_noise());
        end
        tx_steady = 1'b0;
    endtask

    // Short bursts, each followed by a full drain
    task automatic test_drain_pause(input int bursts);
        repeat (bursts) begin
            repeat (rand_between(1, 12))
                send_query(make_planar());
            wait_drained();
        end
    endtask

    // Full rate on both sides with no idling at all
    task automatic test_steady_burst(input int count);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (count)
            send_query(make_planar());
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_planar(720);
        test_noise(400);
        test_backpressure(60);
        test_drain_pause(6);
        test_steady_burst(200);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d queries (%0d checked): %0d inside, %0d within prism, %0d on plane",
                 n_sent, n_checked, n_inside, n_prism, n_plane);
        $display("included a %0d-cycle output hold-off, drain pauses and a full-rate burst",
                 HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("[point_in_triangle_3d] OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("[point_in_triangle_3d] ERROR");
        end
        $finish;
    end

endmodule
